### rtl/core/cdq_pkg.sv
// Package for the circular deque: item types, command and status codes,
// and the index helpers used by the controller.
// Depends on nothing.
package cdq_pkg;

  localparam int Depth  = 64;
  localparam int IdxW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int WordW  = 32;

  typedef logic [IdxW-1:0] idx_t;

  typedef enum logic [2:0] {
    CmdPushRear  = 3'd0,
    CmdPushFront = 3'd1,
    CmdPopRear   = 3'd2,
    CmdPopFront  = 3'd3,
    CmdList      = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StOverflow  = 3'd1,
    StUnderflow = 3'd2,
    StEmpty     = 3'd3,
    StRefused   = 3'd4
  } status_e;

  localparam logic [1:0] ModeInRestr  = 2'd1;
  localparam logic [1:0] ModeOutRestr = 2'd2;

  typedef struct packed {
    logic [2:0]              command;
    logic signed [WordW-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    status_e                 status;
    logic signed [WordW-1:0] out_value;
    logic                    last;
  } out_item_t;

  // Controller view exported to the top level for checking.
  typedef struct packed {
    logic busy;
    logic empty;
    idx_t front;
    idx_t rear;
  } cdq_stat_t;

  function automatic idx_t wrap_inc(idx_t i);
    idx_t r;
    r = (i == idx_t'(Depth - 1)) ? '0 : idx_t'(i + idx_t'(1));
    return r;
  endfunction

  function automatic idx_t wrap_dec(idx_t i);
    idx_t r;
    r = (i == '0) ? idx_t'(Depth - 1) : idx_t'(i - idx_t'(1));
    return r;
  endfunction

endpackage

### rtl/core/cdq_ram.sv
// Word store of the deque: one write port, one read port, registered read data.
// Depends on cdq_pkg for depth and word width.
module cdq_ram
  import cdq_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  idx_t             waddr_i,
  input  logic [WordW-1:0] wdata_i,
  input  logic             re_i,
  input  idx_t             raddr_i,
  output logic [WordW-1:0] rdata_o
);

  logic [WordW-1:0] mem [Depth];
  logic [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read, so a stalled result keeps its word.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/cdq_ctrl.sv
// Deque controller: decodes commands, keeps the front and rear indices, the
// empty flag and the mode register, and sequences store reads for pops and lists.
// Depends on cdq_pkg and instantiates cdq_ram.
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic      out_free_i,
  output logic      res_load_o,
  output out_item_t res_o,
  output cdq_stat_t stat_o
);

  typedef enum logic [2:0] {
    StateIdle = 3'b001,
    StatePop  = 3'b010,
    StateList = 3'b100
  } state_e;

  state_e     state_q, state_d;
  idx_t       front_q, front_d;
  idx_t       rear_q, rear_d;
  idx_t       cur_q, cur_d;
  logic       empty_q, empty_d;
  logic [1:0] mode_q;

  logic             accept;
  logic             full;
  logic             we;
  idx_t             waddr;
  logic             re;
  idx_t             raddr;
  logic [WordW-1:0] rdata;

  cdq_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_item_i.push_value),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_stall_o = !((state_q == StateIdle) && out_free_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = !empty_q && (wrap_inc(rear_q) == front_q);

  always_comb begin
    state_d    = state_q;
    front_d    = front_q;
    rear_d     = rear_q;
    cur_d      = cur_q;
    empty_d    = empty_q;
    we         = 1'b0;
    waddr      = '0;
    re         = 1'b0;
    raddr      = '0;
    res_load_o = 1'b0;
    res_o      = '{status: StOk, out_value: '0, last: 1'b1};

    case (state_q)
      StateIdle: begin
        if (accept) begin
          case (in_item_i.command)
            CmdPushRear, CmdPushFront: begin
              res_load_o = 1'b1;
              if (in_item_i.command == CmdPushFront && mode_q == ModeInRestr) begin
                res_o.status = StRefused;
              end else if (full) begin
                res_o.status = StOverflow;
              end else begin
                we = 1'b1;
                if (empty_q) begin
                  front_d = '0;
                  rear_d  = '0;
                  empty_d = 1'b0;
                  waddr   = '0;
                end else if (in_item_i.command == CmdPushRear) begin
                  rear_d = wrap_inc(rear_q);
                  waddr  = wrap_inc(rear_q);
                end else begin
                  front_d = wrap_dec(front_q);
                  waddr   = wrap_dec(front_q);
                end
              end
            end
            CmdPopRear, CmdPopFront: begin
              if (in_item_i.command == CmdPopRear && mode_q == ModeOutRestr) begin
                res_load_o   = 1'b1;
                res_o.status = StRefused;
              end else if (empty_q) begin
                res_load_o   = 1'b1;
                res_o.status = StUnderflow;
              end else begin
                // The word comes out of the store next cycle.
                re      = 1'b1;
                state_d = StatePop;
                raddr   = (in_item_i.command == CmdPopRear) ? rear_q : front_q;
                if (front_q == rear_q) begin
                  empty_d = 1'b1;
                  front_d = '0;
                  rear_d  = '0;
                end else if (in_item_i.command == CmdPopRear) begin
                  rear_d = wrap_dec(rear_q);
                end else begin
                  front_d = wrap_inc(front_q);
                end
              end
            end
            CmdList: begin
              if (empty_q) begin
                res_load_o   = 1'b1;
                res_o.status = StEmpty;
              end else begin
                re      = 1'b1;
                raddr   = front_q;
                cur_d   = front_q;
                state_d = StateList;
              end
            end
            default: begin
              res_load_o   = 1'b1;
              res_o.status = StRefused;
            end
          endcase
        end
      end
      StatePop: begin
        if (out_free_i) begin
          res_load_o      = 1'b1;
          res_o.out_value = rdata;
          state_d         = StateIdle;
        end
      end
      StateList: begin
        // One stored word per cycle while the output is free; the next read is issued as this one leaves.
        if (out_free_i) begin
          res_load_o      = 1'b1;
          res_o.out_value = rdata;
          res_o.last      = (cur_q == rear_q);
          if (cur_q == rear_q) begin
            state_d = StateIdle;
          end else begin
            cur_d = wrap_inc(cur_q);
            re    = 1'b1;
            raddr = wrap_inc(cur_q);
          end
        end
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateIdle;
      front_q <= '0;
      rear_q  <= '0;
      cur_q   <= '0;
      empty_q <= 1'b1;
      mode_q  <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      rear_q  <= rear_d;
      cur_q   <= cur_d;
      empty_q <= empty_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  assign stat_o = '{busy: (state_q != StateIdle), empty: empty_q,
                    front: front_q, rear: rear_q};

endmodule

### rtl/core/circular_deque_unit.sv
// Top level of the circular deque: controller with its store and the result register.
// Depends on cdq_pkg and instantiates cdq_ctrl.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o   in_item_i  (in_item_t)
//   out      output     out_valid_o / out_stall_i out_item_o (out_item_t)
//   cfg      input      cfg_we_i                  cfg_wdata_i (restriction mode)
//
// The result of a push or of a refused or failed command is registered at the
// accepting edge. A pop first reads the store, then registers the word as its result.
// A list reads the store from front to rear, one result per stored word, the last marked.
// Reset empties the deque and clears the mode; the store itself is not cleared.
// A stalled result holds the block; a new item is taken only when idle and the
// result register is empty or being emptied in the same cycle.
module circular_deque_unit
  import cdq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i
);

  logic      out_valid_q;
  out_item_t out_item_q;
  logic      out_free;
  logic      res_load;
  out_item_t res;
  cdq_stat_t stat;

  assign out_free = !out_valid_q || !out_stall_i;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_free_i  (out_free),
    .res_load_o  (res_load),
    .res_o       (res),
    .stat_o      (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // An item is only taken when its result has somewhere to go.
  a_accept_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> out_free)
    else $error("item accepted while result register is blocked");

  // Only list results can be non-final, and those are always ok.
  a_notlast_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.last) |-> (out_item_o.status == StOk))
    else $error("non-final result with failing status");

  // An empty deque always has both indices at zero.
  a_empty_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.empty |-> (stat.front == '0 && stat.rear == '0))
    else $error("empty deque with nonzero indices");

  // While a pop or list is under way no new item gets in.
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy |-> in_stall_o)
    else $error("item accepted while busy");

endmodule
